// ===== hdl/fflt_pkg.sv =====
// Shared types and constants for the loadable-tap FIR filter.
package fflt_pkg;

    // Width of the tap-count register.
    localparam int TAPS_W = 7;
    // Tap-count reset value.
    localparam logic [TAPS_W-1:0] TAPS_RESET = 7'd32;
    // Used tap count is rounded up to a multiple of this.
    localparam int TAP_ALIGN = 4;
    // Width of the coefficient index field.
    localparam int IDX_W = 6;
    // Accumulator width; sums wrap at this width.
    localparam int ACC_WIDTH = 64;

    // Input command codes.
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // Per-cell controls for the current cycle.
    typedef struct packed {
        logic clear;       // zero the history word
        logic shift_hist;  // take the history word from the neighbor
        logic shift_coef;  // take the coefficient from the neighbor
        logic load;        // write the coefficient from the load request
    } t_cell_ctl;

endpackage

// ===== hdl/fflt_in_if.sv =====
// Input channel: filter and coefficient load requests.
interface fflt_in_if #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 18
);
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic [5:0]                     coef_index;
    logic signed [COEF_WIDTH-1:0]   coef_value;

    modport source (output valid, cmd, sample_in, coef_index, coef_value, input ready);
    modport sink   (input valid, cmd, sample_in, coef_index, coef_value, output ready);
endinterface

// ===== hdl/fflt_out_if.sv =====
// Output channel: filtered samples.
interface fflt_out_if #(
    parameter int SAMPLE_WIDTH = 24
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           clipped;

    modport source (output valid, sample_out, clipped, input ready);
    modport sink   (input valid, sample_out, clipped, output ready);
endinterface

// ===== hdl/fflt_cfg_if.sv =====
// Configuration channel: writes of the tap-count register.
interface fflt_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] taps_selected;

    modport source (output valid, taps_selected, input ready);
    modport sink   (input valid, taps_selected, output ready);
endinterface

// ===== hdl/fflt_cell.sv =====
// One filter cell: a history word and its coefficient, shifted along the chain.
module fflt_cell #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 18
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fflt_pkg::t_cell_ctl            i_ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_hist_nbr,
    input  logic signed [COEF_WIDTH-1:0]   i_coef_nbr,
    input  logic signed [COEF_WIDTH-1:0]   i_coef_wr,
    output logic signed [SAMPLE_WIDTH-1:0] o_hist,
    output logic signed [COEF_WIDTH-1:0]   o_coef
);
    import fflt_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] r_hist;
    logic signed [COEF_WIDTH-1:0]   r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_coef <= '0;
        end else begin
            priority if (i_ctl.clear) begin
                r_hist <= '0;
            end else if (i_ctl.shift_hist) begin
                r_hist <= i_hist_nbr;
            end else begin
                r_hist <= r_hist;
            end
            priority if (i_ctl.load) begin
                r_coef <= i_coef_wr;
            end else if (i_ctl.shift_coef) begin
                r_coef <= i_coef_nbr;
            end else begin
                r_coef <= r_coef;
            end
        end
    end

    assign o_hist = r_hist;
    assign o_coef = r_coef;
endmodule

// ===== hdl/fflt_mac.sv =====
// Multiply-accumulate at the head of the chain, with rounding and saturation.
module fflt_mac #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 18
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_clear,
    input  logic                           i_en,
    input  logic signed [SAMPLE_WIDTH-1:0] i_hist,
    input  logic signed [COEF_WIDTH-1:0]   i_coef,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample,
    output logic                           o_clipped
);
    import fflt_pkg::*;

    localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
    localparam logic signed [ACC_WIDTH-1:0] RND_HALF = ACC_WIDTH'(64'sd1 <<< (COEF_WIDTH - 2));
    localparam logic signed [ACC_WIDTH-1:0] SAT_HI =
        ACC_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_WIDTH-1:0] SAT_LO = -SAT_HI - ACC_WIDTH'(64'sd1);

    logic signed [PROD_W-1:0]    r_prod;
    logic                        r_pv;
    logic signed [ACC_WIDTH-1:0] r_acc;
    logic signed [ACC_WIDTH-1:0] w_sum;
    logic signed [ACC_WIDTH-1:0] w_rounded;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_hist * i_coef;
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_pv) begin
            r_acc <= r_acc + ACC_WIDTH'(r_prod);
        end
    end

    // Adding half an LSB and then a floor shift rounds halves upward.
    always_comb begin
        w_sum     = r_acc + RND_HALF;
        w_rounded = w_sum >>> (COEF_WIDTH - 1);
        o_clipped = 1'b0;
        o_sample  = SAMPLE_WIDTH'(w_rounded);
        if (w_rounded > SAT_HI) begin
            o_sample  = SAMPLE_WIDTH'(SAT_HI);
            o_clipped = 1'b1;
        end else if (w_rounded < SAT_LO) begin
            o_sample  = SAMPLE_WIDTH'(SAT_LO);
            o_clipped = 1'b1;
        end
    end
endmodule

// ===== hdl/fflt_chain.sv =====
// Row of filter cells; the first N cells rotate as a ring through the head.
module fflt_chain #(
    parameter int MAX_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 18,
    parameter int NW           = 7
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [NW-1:0]                  i_n_used,
    input  logic                           i_clear,
    input  logic                           i_shift_hist,
    input  logic                           i_shift_coef,
    input  logic                           i_first,
    input  logic signed [SAMPLE_WIDTH-1:0] i_cur,
    input  logic                           i_load,
    input  logic [5:0]                     i_load_idx,
    input  logic signed [COEF_WIDTH-1:0]   i_coef_wr,
    output logic signed [SAMPLE_WIDTH-1:0] o_head_hist,
    output logic signed [COEF_WIDTH-1:0]   o_head_coef
);
    import fflt_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] w_hist [MAX_TAPS];
    logic signed [COEF_WIDTH-1:0]   w_coef [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] w_hist_feed;

    // On the first step the new sample replaces the oldest word in the ring.
    assign w_hist_feed = i_first ? i_cur : w_hist[0];

    for (genvar t = 0; t < MAX_TAPS; t++) begin : g_cell
        t_cell_ctl                      w_ctl;
        logic                           w_active;
        logic signed [SAMPLE_WIDTH-1:0] w_hist_nbr;
        logic signed [COEF_WIDTH-1:0]   w_coef_nbr;

        assign w_active = 32'(i_n_used) > t;

        if (t == MAX_TAPS - 1) begin : g_last
            assign w_hist_nbr = w_hist_feed;
            assign w_coef_nbr = w_coef[0];
        end else begin : g_mid
            logic w_wrap;
            assign w_wrap     = 32'(i_n_used) == t + 1;
            assign w_hist_nbr = w_wrap ? w_hist_feed : w_hist[t+1];
            assign w_coef_nbr = w_wrap ? w_coef[0] : w_coef[t+1];
        end

        assign w_ctl.clear      = i_clear;
        assign w_ctl.shift_hist = i_shift_hist && w_active;
        assign w_ctl.shift_coef = i_shift_coef && w_active;
        assign w_ctl.load       = i_load && (32'(i_load_idx) == t);

        fflt_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .COEF_WIDTH   (COEF_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_hist_nbr (w_hist_nbr),
            .i_coef_nbr (w_coef_nbr),
            .i_coef_wr  (i_coef_wr),
            .o_hist     (w_hist[t]),
            .o_coef     (w_coef[t])
        );
    end

    assign o_head_hist = w_hist[0];
    assign o_head_coef = w_coef[0];
endmodule

// ===== hdl/fir_filter_loadable_taps_core.sv =====
// Direct-form FIR filter with loadable taps. A load request writes one coefficient. A filter
// request runs over N taps, where N is the used tap count (max(1, taps_selected) rounded up
// to a multiple of four, at most MAX_TAPS): the taps sit in a row of cells that rotates
// through one multiplier at its head, one tap per cycle, then a step in which the last
// product is added while the history finishes its turn, then the rounding and saturation
// into the output register, then the return to idle, where the next request is taken. Each
// result waits in an output register, so the next request may be accepted before it is
// taken; a result that is ready while the previous one is still waiting holds the filter
// until the register frees up. Writing a different tap count clears the sample history.
module fir_filter_loadable_taps_core #(
    parameter int MAX_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 24,
    parameter int COEF_WIDTH   = 18
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fflt_in_if.sink    i_in,
    fflt_out_if.source o_out,
    fflt_cfg_if.sink   i_cfg
);
    import fflt_pkg::*;

    localparam int NW = $clog2(MAX_TAPS + 1);
    localparam logic [7:0] ALIGN_MASK = 8'(~(TAP_ALIGN - 1));

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic [NW-1:0]                  r_cnt;
    logic [NW-1:0]                  n_cnt;
    logic [TAPS_W-1:0]              r_taps;
    logic signed [SAMPLE_WIDTH-1:0] r_cur;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_sample_out;
    logic                           r_clipped;

    logic [7:0]                     w_x;
    logic [7:0]                     w_rnd;
    logic [NW-1:0]                  w_n_used;
    logic                           w_acc_in;
    logic                           w_start;
    logic                           w_load;
    logic                           w_cfg_wr;
    logic                           w_clear;
    logic                           w_out_free;
    logic                           w_finish;
    logic                           w_shift_coef;
    logic signed [SAMPLE_WIDTH-1:0] w_head_hist;
    logic signed [COEF_WIDTH-1:0]   w_head_coef;
    logic signed [SAMPLE_WIDTH-1:0] w_mac_sample;
    logic                           w_mac_clipped;

    // Used tap count.
    always_comb begin
        w_x   = (r_taps == '0) ? 8'd1 : 8'(r_taps);
        w_rnd = (w_x + 8'(TAP_ALIGN - 1)) & ALIGN_MASK;
        w_n_used = (32'(w_rnd) > MAX_TAPS) ? NW'(MAX_TAPS) : NW'(w_rnd);
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign w_acc_in = i_in.valid && i_in.ready;
    assign w_start  = w_acc_in && (i_in.cmd == CMD_FILTER);
    assign w_load   = w_acc_in && (i_in.cmd == CMD_LOAD)
                      && (32'(i_in.coef_index) < MAX_TAPS);
    assign w_cfg_wr = i_cfg.valid && i_cfg.ready;
    assign w_clear  = w_cfg_wr && (i_cfg.taps_selected != r_taps);

    assign w_out_free   = !r_out_valid || o_out.ready;
    assign w_finish     = (r_state == S_FIN) && w_out_free;
    assign w_shift_coef = (r_state == S_RUN) && (r_cnt != w_n_used);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = S_RUN;
                    n_cnt   = '0;
                end
            end
            S_RUN: begin
                // History turns N + 1 times, coefficients N times.
                if (r_cnt == w_n_used) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + NW'(1);
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_taps      <= TAPS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_cfg_wr) begin
                r_taps <= i_cfg.taps_selected;
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_cur <= i_in.sample_in;
        end
        if (w_finish) begin
            r_sample_out <= w_mac_sample;
            r_clipped    <= w_mac_clipped;
        end
    end

    fflt_chain #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .NW           (NW)
    ) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_n_used     (w_n_used),
        .i_clear      (w_clear),
        .i_shift_hist (r_state == S_RUN),
        .i_shift_coef (w_shift_coef),
        .i_first      (r_cnt == '0),
        .i_cur        (r_cur),
        .i_load       (w_load),
        .i_load_idx   (i_in.coef_index),
        .i_coef_wr    (i_in.coef_value),
        .o_head_hist  (w_head_hist),
        .o_head_coef  (w_head_coef)
    );

    fflt_mac #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_start),
        .i_en      (w_shift_coef),
        .i_hist    (w_head_hist),
        .i_coef    (w_head_coef),
        .o_sample  (w_mac_sample),
        .o_clipped (w_mac_clipped)
    );

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_sample_out;
    assign o_out.clipped    = r_clipped;
endmodule
